>>> sv/shape_rasterizer_top_assert.svh
// Assertion macros used by the rasterizer top.
`ifndef SHAPE_RASTERIZER_TOP_ASSERT_SVH
`define SHAPE_RASTERIZER_TOP_ASSERT_SVH

// Holds a property at every clock edge outside reset.
`define SR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/sr_pkg.sv
package sr_pkg;
  localparam int CanvasW = 128;
  localparam int CanvasH = 64;
  localparam int XW = $clog2(CanvasW);
  localparam int YW = $clog2(CanvasH);
  localparam int AW = XW + YW;
  localparam int Depth = CanvasW * CanvasH;
  localparam int MidInit = 3;
  localparam int MidDiag = 10;
  localparam int MidAxial = 6;
  localparam int MidScale = 4;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0, OP_LINE = 3'd1, OP_RECT_O = 3'd2, OP_RECT_F = 3'd3,
    OP_CIRC_O = 3'd4, OP_CIRC_F = 3'd5, OP_TRI = 3'd6, OP_READ = 3'd7
  } op_t;
endpackage

>>> sv/shape_rasterizer_top.sv
// Shape rasteriser over a CanvasW x CanvasH one-bit canvas held in a single
// synchronous RAM (one bit per word, one write port, one read port). Each
// request (clear, line, rectangle, circle, triangle, pixel read) yields one
// result carrying done_type and, for reads, pixel_value. One request is worked
// at a time; a drawing sequencer emits at most one plot per cycle. A line walks
// from end to end, a triangle draws three such lines, an outlined rectangle
// walks its four sides unclipped, a filled rectangle or circle walks its clipped
// bounding box, a circle outline plots eight octant points per step and a read
// passes S_READ and S_READW; each request then raises its result in S_DONE,
// waits for it to be taken and returns to S_IDLE. Clear sweeps every word, then
// returns its result. After reset the same sweep runs once before the first
// request is accepted. Off-canvas plots are dropped; the result sits in an
// output register until taken.
`include "shape_rasterizer_top_assert.svh"
module shape_rasterizer_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         req_type,
  input  logic signed [11:0] pa_x,
  input  logic signed [11:0] pa_y,
  input  logic signed [11:0] pb_x,
  input  logic signed [11:0] pb_y,
  input  logic signed [11:0] pc_x,
  input  logic signed [11:0] pc_y,
  input  logic signed [11:0] extent_w,
  input  logic signed [11:0] extent_h,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               pixel_value,
  output logic [2:0]         done_type
);
  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_LINE, S_RECTO, S_FILL, S_CIRC, S_READ, S_READW, S_DONE
  } state_t;

  state_t state;
  sr_pkg::op_t op;
  logic [sr_pkg::AW:0] sweep;
  // working coordinates (wide so off-canvas arithmetic never wraps)
  logic signed [15:0] x, y, x1, y1, dx, dy, stx, sty, e;
  logic signed [15:0] bx, by, cx, cy, ax0, ay0;
  logic [1:0] seg;
  // rectangle / fill bounds
  logic signed [15:0] lo_x, hi_x, hi_y, ox, oy;
  logic [1:0] side;
  logic signed [31:0] rr, sq;
  logic signed [15:0] d, cxo, cyo;
  logic [2:0] oct;

  // plot request
  logic plot;
  logic signed [15:0] px, py;
  logic we;
  logic [sr_pkg::AW-1:0] waddr, raddr;
  logic wdata, rdata;
  logic [sr_pkg::AW-1:0] raddr_q;
  logic read_on;

  function automatic logic on_c(input logic signed [15:0] a, input logic signed [15:0] b);
    on_c = (a >= 0) && (a < 16'(sr_pkg::CanvasW)) && (b >= 0) && (b < 16'(sr_pkg::CanvasH));
  endfunction

  assign we    = (state == S_SWEEP) || (plot && on_c(px, py));
  assign waddr = (state == S_SWEEP) ? sweep[sr_pkg::AW-1:0]
                 : {py[sr_pkg::YW-1:0], px[sr_pkg::XW-1:0]};
  assign wdata = (state != S_SWEEP);
  assign raddr = {pa_y[sr_pkg::YW-1:0], pa_x[sr_pkg::XW-1:0]};

  sr_ram #(.Width(1), .Depth(sr_pkg::Depth)) u_canvas (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr_q), .rdata(rdata)
  );

  assign in_stall = (state != S_IDLE);

  // circle octant point and plot selection
  always_comb begin
    plot = 1'b0;
    px = x;
    py = y;
    sq = 32'(ox) * 32'(ox) + 32'(oy) * 32'(oy);
    unique case (state)
      S_LINE: plot = 1'b1;
      S_RECTO: begin
        plot = 1'b1;
      end
      S_FILL: begin
        // filled rectangle walks absolute coordinates, filled circle offsets
        px = (op == sr_pkg::OP_RECT_F) ? ox : cx + ox;
        py = (op == sr_pkg::OP_RECT_F) ? oy : cy + oy;
        plot = (ox <= hi_x) && (oy <= hi_y) && ((op == sr_pkg::OP_RECT_F) || (sq <= rr));
      end
      S_CIRC: begin
        plot = 1'b1;
        case (oct)
          3'd0: begin px = cx + x; py = cy + y; end
          3'd1: begin px = cx - x; py = cy + y; end
          3'd2: begin px = cx + x; py = cy - y; end
          3'd3: begin px = cx - x; py = cy - y; end
          3'd4: begin px = cx + y; py = cy + x; end
          3'd5: begin px = cx - y; py = cy + x; end
          3'd6: begin px = cx + y; py = cy - x; end
          default: begin px = cx - y; py = cy - x; end
        endcase
      end
      default: plot = 1'b0;
    endcase
  end

  // Bresenham step helpers
  logic signed [16:0] e2;
  assign e2 = 17'(e) <<< 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      sweep     <= '0;
      out_valid <= 1'b0;
      op        <= sr_pkg::OP_READ;  // power-up sweep gives no result
    end else begin
      unique case (state)
        S_SWEEP: begin
          sweep <= sweep + 1'b1;
          if (sweep == (sr_pkg::AW+1)'(sr_pkg::Depth - 1))
            state <= (op == sr_pkg::OP_CLEAR) ? S_DONE : S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          op  <= sr_pkg::op_t'(req_type);
          cx  <= 16'(pa_x);
          cy  <= 16'(pa_y);
          ax0 <= 16'(pa_x);
          ay0 <= 16'(pa_y);
          bx  <= 16'(pb_x);
          by  <= 16'(pb_y);
          cxo <= 16'(pc_x);
          cyo <= 16'(pc_y);
          seg <= 2'd0;
          pixel_value <= 1'b0;
          unique case (sr_pkg::op_t'(req_type))
            sr_pkg::OP_CLEAR: begin sweep <= '0; state <= S_SWEEP; end
            sr_pkg::OP_LINE, sr_pkg::OP_TRI: begin
              x <= 16'(pa_x); y <= 16'(pa_y); x1 <= 16'(pb_x); y1 <= 16'(pb_y);
              dx <= (pb_x > pa_x) ? 16'(pb_x) - 16'(pa_x) : 16'(pa_x) - 16'(pb_x);
              dy <= (pb_y > pa_y) ? 16'(pb_y) - 16'(pa_y) : 16'(pa_y) - 16'(pb_y);
              stx <= (pa_x < pb_x) ? 16'sd1 : -16'sd1;
              sty <= (pa_y < pb_y) ? 16'sd1 : -16'sd1;
              e <= ((pb_x > pa_x) ? 16'(pb_x) - 16'(pa_x) : 16'(pa_x) - 16'(pb_x))
                 - ((pb_y > pa_y) ? 16'(pb_y) - 16'(pa_y) : 16'(pa_y) - 16'(pb_y));
              state <= S_LINE;
            end
            sr_pkg::OP_RECT_O: begin
              if (extent_w <= 0 || extent_h <= 0) state <= S_DONE;
              else begin
                x <= 16'(pa_x); y <= 16'(pa_y);
                lo_x <= 16'(pa_x) + 16'(extent_w) - 16'sd1;
                hi_y <= 16'(pa_y) + 16'(extent_h) - 16'sd1;
                side <= 2'd0;
                state <= S_RECTO;
              end
            end
            sr_pkg::OP_RECT_F: begin
              if (extent_w <= 0 || extent_h <= 0) state <= S_DONE;
              else begin
                // clip box to canvas
                ox <= (pa_x < 0) ? 16'sd0 : 16'(pa_x);
                oy <= (pa_y < 0) ? 16'sd0 : 16'(pa_y);
                lo_x <= (pa_x < 0) ? 16'sd0 : 16'(pa_x);
                hi_x <= (16'(pa_x) + 16'(extent_w) - 16'sd1 > 16'(sr_pkg::CanvasW - 1))
                        ? 16'(sr_pkg::CanvasW - 1) : 16'(pa_x) + 16'(extent_w) - 16'sd1;
                hi_y <= (16'(pa_y) + 16'(extent_h) - 16'sd1 > 16'(sr_pkg::CanvasH - 1))
                        ? 16'(sr_pkg::CanvasH - 1) : 16'(pa_y) + 16'(extent_h) - 16'sd1;
                state <= S_FILL;
              end
            end
            sr_pkg::OP_CIRC_O: begin
              if (extent_w < 0) state <= S_DONE;
              else begin
                x <= '0; y <= 16'(extent_w); oct <= '0;
                d <= 16'(sr_pkg::MidInit) - (16'(extent_w) <<< 1);
                state <= S_CIRC;
              end
            end
            sr_pkg::OP_CIRC_F: begin
              if (extent_w < 0) state <= S_DONE;
              else begin
                rr <= 32'(extent_w) * 32'(extent_w);
                ox <= (-16'(extent_w) > -16'(pa_x)) ? -16'(extent_w) : -16'(pa_x);
                lo_x <= (-16'(extent_w) > -16'(pa_x)) ? -16'(extent_w) : -16'(pa_x);
                oy <= (-16'(extent_w) > -16'(pa_y)) ? -16'(extent_w) : -16'(pa_y);
                hi_x <= (16'(extent_w) < 16'(sr_pkg::CanvasW - 1) - 16'(pa_x))
                        ? 16'(extent_w) : 16'(sr_pkg::CanvasW - 1) - 16'(pa_x);
                hi_y <= (16'(extent_w) < 16'(sr_pkg::CanvasH - 1) - 16'(pa_y))
                        ? 16'(extent_w) : 16'(sr_pkg::CanvasH - 1) - 16'(pa_y);
                state <= S_FILL;
              end
            end
            default: state <= S_READ;
          endcase
        end
        S_LINE: begin
          if (x == x1 && y == y1) begin
            if (op == sr_pkg::OP_TRI && seg != 2'd2) begin
              seg <= seg + 2'd1;
              // next edge: b->c, then c->a
              x1 <= (seg == 2'd0) ? cxo : ax0;
              y1 <= (seg == 2'd0) ? cyo : ay0;
              begin : nxt
                logic signed [15:0] tx, ty, ddx, ddy;
                tx = (seg == 2'd0) ? cxo : ax0;
                ty = (seg == 2'd0) ? cyo : ay0;
                ddx = (tx > x) ? tx - x : x - tx;
                ddy = (ty > y) ? ty - y : y - ty;
                dx <= ddx; dy <= ddy; e <= ddx - ddy;
                stx <= (x < tx) ? 16'sd1 : -16'sd1;
                sty <= (y < ty) ? 16'sd1 : -16'sd1;
              end
            end else state <= S_DONE;
          end else begin
            if (e2 > -17'(dy) && e2 < 17'(dx)) begin
              e <= e - dy + dx; x <= x + stx; y <= y + sty;
            end else if (e2 > -17'(dy)) begin
              e <= e - dy; x <= x + stx;
            end else if (e2 < 17'(dx)) begin
              e <= e + dx; y <= y + sty;
            end
          end
        end
        S_RECTO: begin
          // sides: top row, bottom row, left column, right column
          unique case (side)
            2'd0: if (x == lo_x) begin x <= ax0; y <= hi_y; side <= 2'd1; end
                  else x <= x + 16'sd1;
            2'd1: if (x == lo_x) begin x <= ax0; y <= ay0; side <= 2'd2; end
                  else x <= x + 16'sd1;
            2'd2: if (y == hi_y) begin x <= lo_x; y <= ay0; side <= 2'd3; end
                  else y <= y + 16'sd1;
            default: if (y == hi_y) state <= S_DONE;
                     else y <= y + 16'sd1;
          endcase
        end
        S_FILL: begin
          if (ox >= hi_x || oy > hi_y) begin
            ox <= lo_x;
            oy <= oy + 16'sd1;
            if (oy >= hi_y) state <= S_DONE;
          end else ox <= ox + 16'sd1;
        end
        S_CIRC: begin
          oct <= oct + 3'd1;
          if (oct == 3'd7) begin
            // stop once the stepped y falls below the stepped x
            if (y - ((d > 0) ? 16'sd1 : 16'sd0) < x + 16'sd1) state <= S_DONE;
            if (d > 0) begin
              y <= y - 16'sd1;
              d <= d + 16'(sr_pkg::MidScale) * (x - y + 16'sd1) + 16'(sr_pkg::MidDiag);
            end else
              d <= d + 16'(sr_pkg::MidScale) * x + 16'(sr_pkg::MidAxial);
            x <= x + 16'sd1;
          end
        end
        S_READ: state <= S_READW;
        S_READW: begin
          pixel_value <= read_on & rdata;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            done_type <= op;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      raddr_q <= raddr;
      read_on <= on_c(16'(pa_x), 16'(pa_y));
    end
  end

  `SR_ASSERT(a_one_result, !(out_valid && state != S_DONE), "result outside done")
  `SR_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `SR_ASSERT(a_idle_ready, (state == S_IDLE) == !in_stall, "ready mismatch")
endmodule

>>> sv/sr_ram.sv
module sr_ram #(
  parameter int Width = 1,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> test/tb.sv
module tb;
  // One draw request as driven onto the ports.
  typedef struct {
    sr_pkg::op_t        op;
    logic signed [11:0] ax, ay, bx, by, qx, qy, ew, eh;
  } draw_req_t;

  // Result the canvas model says the block must return.
  typedef struct {
    bit          pix;
    sr_pkg::op_t op;
  } draw_done_t;

  // Canvas model plus the queue of outstanding results.
  class raster_board;
    bit         canvas[sr_pkg::Depth];
    draw_done_t pending[$];
    int         errors;
    int         checked;
    int         lit_reads;

    function void plot(int x, int y);
      if (x >= 0 && x < sr_pkg::CanvasW && y >= 0 && y < sr_pkg::CanvasH)
        canvas[y * sr_pkg::CanvasW + x] = 1'b1;
    endfunction

    function void stroke(int x0, int y0, int x1, int y1);
      int dx, dy, stx, sty, e, e2;
      dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy  = (y1 > y0) ? y1 - y0 : y0 - y1;
      stx = (x0 < x1) ? 1 : -1;
      sty = (y0 < y1) ? 1 : -1;
      e   = dx - dy;
      forever begin
        plot(x0, y0);
        if (x0 == x1 && y0 == y1) break;
        e2 = 2 * e;
        if (e2 > -dy) begin
          e -= dy;
          x0 += stx;
        end
        if (e2 < dx) begin
          e += dx;
          y0 += sty;
        end
      end
    endfunction

    function void box(int x, int y, int w, int h, bit fill);
      if (w <= 0 || h <= 0) return;
      if (fill) begin
        for (int j = y; j < y + h; j++) begin
          if (j < 0 || j >= sr_pkg::CanvasH) continue;
          for (int i = x; i < x + w; i++) plot(i, j);
        end
      end else begin
        for (int i = x; i < x + w; i++) begin
          plot(i, y);
          plot(i, y + h - 1);
        end
        for (int j = y; j < y + h; j++) begin
          plot(x, j);
          plot(x + w - 1, j);
        end
      end
    endfunction

    function void ring(int cx, int cy, int r, bit fill);
      int x, y, d, rr, dy0, dy1, dx0, dx1;
      if (r < 0) return;
      if (r == 0) begin
        plot(cx, cy);
        return;
      end
      if (fill) begin
        rr  = r * r;
        dy0 = (-r > -cy) ? -r : -cy;
        dy1 = (r < sr_pkg::CanvasH - 1 - cy) ? r : sr_pkg::CanvasH - 1 - cy;
        dx0 = (-r > -cx) ? -r : -cx;
        dx1 = (r < sr_pkg::CanvasW - 1 - cx) ? r : sr_pkg::CanvasW - 1 - cx;
        for (int j = dy0; j <= dy1; j++)
          for (int i = dx0; i <= dx1; i++)
            if (i * i + j * j <= rr) plot(cx + i, cy + j);
      end else begin
        x = 0;
        y = r;
        d = sr_pkg::MidInit - 2 * r;
        while (y >= x) begin
          plot(cx + x, cy + y); plot(cx - x, cy + y);
          plot(cx + x, cy - y); plot(cx - x, cy - y);
          plot(cx + y, cy + x); plot(cx - y, cy + x);
          plot(cx + y, cy - x); plot(cx - y, cy - x);
          if (d > 0) begin
            y--;
            d = d + sr_pkg::MidScale * (x - y) + sr_pkg::MidDiag;
          end else begin
            d = d + sr_pkg::MidScale * x + sr_pkg::MidAxial;
          end
          x++;
        end
      end
    endfunction

    function void note(draw_req_t c);
      draw_done_t res;
      res.op  = c.op;
      res.pix = 1'b0;
      case (c.op)
        sr_pkg::OP_CLEAR:  foreach (canvas[k]) canvas[k] = 1'b0;
        sr_pkg::OP_LINE:   stroke(c.ax, c.ay, c.bx, c.by);
        sr_pkg::OP_RECT_O: box(c.ax, c.ay, c.ew, c.eh, 1'b0);
        sr_pkg::OP_RECT_F: box(c.ax, c.ay, c.ew, c.eh, 1'b1);
        sr_pkg::OP_CIRC_O: ring(c.ax, c.ay, c.ew, 1'b0);
        sr_pkg::OP_CIRC_F: ring(c.ax, c.ay, c.ew, 1'b1);
        sr_pkg::OP_TRI: begin
          stroke(c.ax, c.ay, c.bx, c.by);
          stroke(c.bx, c.by, c.qx, c.qy);
          stroke(c.qx, c.qy, c.ax, c.ay);
        end
        default: begin
          if (c.ax >= 0 && c.ax < sr_pkg::CanvasW && c.ay >= 0 && c.ay < sr_pkg::CanvasH)
            res.pix = canvas[int'(c.ay) * sr_pkg::CanvasW + int'(c.ax)];
        end
      endcase
      pending.push_back(res);
    endfunction

    function void check(logic pix, logic [2:0] dt);
      draw_done_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: done_type=%0d pixel=%b", dt, pix);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.op == sr_pkg::OP_READ && want.pix) lit_reads++;
      if (pix !== want.pix || dt !== want.op) begin
        errors++;
        if (errors <= 10)
          $display("mismatch #%0d: expected type=%0d pixel=%b, got type=%0d pixel=%b",
                   checked, want.op, want.pix, dt, pix);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         req_type = sr_pkg::OP_CLEAR;
  logic signed [11:0] pa_x = '0, pa_y = '0, pb_x = '0, pb_y = '0;
  logic signed [11:0] pc_x = '0, pc_y = '0, extent_w = '0, extent_h = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               pixel_value;
  logic [2:0]         done_type;

  raster_board board = new();
  bit          quiet;        // no idling in the closing stretch
  int          sent;
  int          per_op[8];

  shape_rasterizer_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Coordinate mostly around the canvas, sometimes far off, rarely anywhere.
  function automatic logic signed [11:0] near(int span);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 85) return 12'(int'($urandom_range(0, span + 12)) - 6);
    if (sel < 97) return 12'(int'($urandom_range(0, span + 80)) - 40);
    return 12'($urandom);
  endfunction

  function automatic logic signed [11:0] extent();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 88) return 12'(int'($urandom_range(0, 24)) - 3);
    if (sel < 98) return 12'(int'($urandom_range(0, 80)) - 20);
    return 12'($urandom);
  endfunction

  function automatic draw_req_t random_req();
    draw_req_t c;
    int sel;
    // unused fields keep full random content
    c.ax = 12'($urandom); c.ay = 12'($urandom);
    c.bx = 12'($urandom); c.by = 12'($urandom);
    c.qx = 12'($urandom); c.qy = 12'($urandom);
    c.ew = 12'($urandom); c.eh = 12'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 2)       c.op = sr_pkg::OP_CLEAR;
    else if (sel < 14) c.op = sr_pkg::OP_LINE;
    else if (sel < 22) c.op = sr_pkg::OP_RECT_O;
    else if (sel < 30) c.op = sr_pkg::OP_RECT_F;
    else if (sel < 38) c.op = sr_pkg::OP_CIRC_O;
    else if (sel < 46) c.op = sr_pkg::OP_CIRC_F;
    else if (sel < 54) c.op = sr_pkg::OP_TRI;
    else               c.op = sr_pkg::OP_READ;
    if (c.op != sr_pkg::OP_CLEAR) begin
      c.ax = near(sr_pkg::CanvasW);
      c.ay = near(sr_pkg::CanvasH);
    end
    if (c.op == sr_pkg::OP_LINE || c.op == sr_pkg::OP_TRI) begin
      c.bx = near(sr_pkg::CanvasW);
      c.by = near(sr_pkg::CanvasH);
    end
    if (c.op == sr_pkg::OP_TRI) begin
      c.qx = near(sr_pkg::CanvasW);
      c.qy = near(sr_pkg::CanvasH);
    end
    if (c.op inside {sr_pkg::OP_RECT_O, sr_pkg::OP_RECT_F, sr_pkg::OP_CIRC_O,
                     sr_pkg::OP_CIRC_F}) c.ew = extent();
    if (c.op inside {sr_pkg::OP_RECT_O, sr_pkg::OP_RECT_F}) c.eh = extent();
    return c;
  endfunction

  function automatic draw_req_t mk(sr_pkg::op_t op, int ax, int ay, int bx, int by,
                                   int qx, int qy, int ew, int eh);
    draw_req_t c;
    c.op = op;
    c.ax = 12'(ax); c.ay = 12'(ay); c.bx = 12'(bx); c.by = 12'(by);
    c.qx = 12'(qx); c.qy = 12'(qy); c.ew = 12'(ew); c.eh = 12'(eh);
    return c;
  endfunction

  // Present one request from a falling edge and hold it until taken.
  task automatic push_req(draw_req_t c);
    int gap;
    req_type = c.op;
    pa_x = c.ax; pa_y = c.ay; pb_x = c.bx; pb_y = c.by;
    pc_x = c.qx; pc_y = c.qy; extent_w = c.ew; extent_h = c.eh;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    board.note(c);
    sent++;
    per_op[c.op]++;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(negedge clk);
    end
  endtask

  // Result side: take at the rising edge, move stall at the falling edge.
  initial begin : result_side
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) board.check(pixel_value, done_type);
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_stall = 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 18);
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  initial begin : stimulus
    draw_req_t dir[$];
    int drain;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extremes, empty shapes, zero radius, off-canvas reads.
    dir.push_back(mk(sr_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(sr_pkg::OP_LINE, -2048, -2048, 2047, 2047, 0, 0, 0, 0));
    dir.push_back(mk(sr_pkg::OP_READ, 10, 10, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(sr_pkg::OP_LINE, 5, 40, 5, 40, 0, 0, 0, 0));        // single point
    dir.push_back(mk(sr_pkg::OP_READ, 5, 40, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(sr_pkg::OP_RECT_O, 20, 20, 0, 0, 0, 0, 0, 5));       // zero width
    dir.push_back(mk(sr_pkg::OP_RECT_F, 30, 20, 0, 0, 0, 0, 5, -2048));   // negative height
    dir.push_back(mk(sr_pkg::OP_RECT_O, 100, 2, 0, 0, 0, 0, 3, 2047));
    dir.push_back(mk(sr_pkg::OP_RECT_F, -2048, 60, 0, 0, 0, 0, 2047, 3));
    dir.push_back(mk(sr_pkg::OP_RECT_F, 10, -10, 0, 0, 0, 0, 5, 3));      // above the top
    dir.push_back(mk(sr_pkg::OP_RECT_F, -20, 10, 0, 0, 0, 0, 5, 3));      // left of canvas
    dir.push_back(mk(sr_pkg::OP_READ, 10, 0, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(sr_pkg::OP_READ, 0, 10, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(sr_pkg::OP_CIRC_O, 60, 30, 0, 0, 0, 0, -1, 0));      // negative radius
    dir.push_back(mk(sr_pkg::OP_CIRC_O, 70, 50, 0, 0, 0, 0, 0, 0));       // centre only
    dir.push_back(mk(sr_pkg::OP_CIRC_F, 71, 51, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(sr_pkg::OP_READ, 70, 50, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(sr_pkg::OP_CIRC_O, 30, 30, 0, 0, 0, 0, 5, 0));
    dir.push_back(mk(sr_pkg::OP_CIRC_O, 64, 32, 0, 0, 0, 0, 2047, 0));
    dir.push_back(mk(sr_pkg::OP_CIRC_F, 2047, -2048, 0, 0, 0, 0, 2047, 0));
    dir.push_back(mk(sr_pkg::OP_TRI, 2, 2, -2048, 2047, 2047, -2048, 0, 0));
    dir.push_back(mk(sr_pkg::OP_READ, -1, 5, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(sr_pkg::OP_READ, 128, 5, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(sr_pkg::OP_READ, 5, 64, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(sr_pkg::OP_READ, -2048, 2047, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(sr_pkg::OP_READ, 127, 63, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(sr_pkg::OP_CLEAR, -1, -1, -1, -1, -1, -1, -1, -1));
    dir.push_back(mk(sr_pkg::OP_READ, 10, 10, 0, 0, 0, 0, 0, 0));
    foreach (dir[k]) push_req(dir[k]);

    for (int n = 0; n < 1030; n++) begin
      if (n == 930) quiet = 1'b1;
      push_req(random_req());
    end
    in_valid = 1'b0;

    // Drain: a clear can take a full sweep of the canvas.
    drain = 0;
    while (board.pending.size() != 0 && drain < 200000) begin
      @(posedge clk);
      drain++;
    end
    repeat (40) @(posedge clk);
    if (board.pending.size() != 0) begin
      board.errors += board.pending.size();
      $display("%0d results never arrived", board.pending.size());
    end
    $display("%0d requests (clear %0d, line %0d, rect %0d/%0d, circle %0d/%0d, tri %0d)",
             sent, per_op[0], per_op[1], per_op[2], per_op[3], per_op[4], per_op[5],
             per_op[6]);
    $display("%0d reads, %0d of them on set pixels; %0d results checked, %0d errors",
             per_op[7], board.lit_reads, board.checked, board.errors);
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #80000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule

>>> files.f
+incdir+sv
sv/sr_pkg.sv
sv/sr_ram.sv
sv/shape_rasterizer_top.sv
test/tb.sv
